FILE: src/pgss_pkg.sv
// Package for the parking gate servo sequencer: request/response structs,
// opcodes, register map and reset values. No dependencies.
package pgss_pkg;

    localparam int BAY_COUNT_DEF = 8;
    localparam int MASK_W        = 8;
    localparam int SLOT_W        = 4;
    localparam int CNT_W         = 16;
    localparam int PULSE_W       = 15;
    localparam int PHASE_W       = 16;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ENTRY = 2'd1,
        OP_EXIT  = 2'd2,
        OP_PHASE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_OPEN_HOLD  = 3'd0,
        REG_BLINK      = 3'd1,
        REG_CLOSED_PW  = 3'd2,
        REG_OPEN_PW    = 3'd3,
        REG_PWM_PERIOD = 3'd4
    } t_reg_idx;

    localparam logic [CNT_W-1:0]   RST_OPEN_HOLD  = 16'd200;
    localparam logic [CNT_W-1:0]   RST_BLINK      = 16'd20;
    localparam logic [PULSE_W-1:0] RST_CLOSED_PW  = 15'd1000;
    localparam logic [PULSE_W-1:0] RST_OPEN_PW    = 15'd2000;
    localparam logic [CNT_W-1:0]   RST_PWM_PERIOD = 16'd20000;

    typedef struct packed {
        t_op                op;
        logic [MASK_W-1:0]  bay_free_mask;
        logic               vehicle_present;
        logic               servo_expiry_pending;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]  free_slots;
        logic               lot_full;
        logic               yellow_on;
        logic               gate_busy;
        logic               servo_level;
        logic               phase_valid;
        logic [PHASE_W-1:0] phase_us;
        logic [PULSE_W-1:0] target_pulse_us;
    } t_rsp;

endpackage

FILE: src/parking_gate_servo_sequencer_top.sv
// Parking gate servo sequencer, top level: input register, event logic,
// result register and APB register bank. Depends on pgss_pkg.
//
//  port group      | direction | handshake        | payload
//  ----------------+-----------+------------------+-------------------------
//  request in      | in        | i_valid/o_ready  | i_req  (t_req)
//  result out      | out       | o_valid/i_ready  | o_rsp  (t_rsp)
//  registers       | in/out    | psel/penable     | paddr/pwdata/prdata
//
// One request per cycle sustained while i_ready is high; an accepted request passes the
// input register, then the result register with the state update, to reach o_valid.
// Result register stalls only when it is full and i_ready is low; the input
// register keeps taking requests while the result register drains.
// Reset is synchronous, active low; registers return to their defaults.
module parking_gate_servo_sequencer_top
    import pgss_pkg::*;
#(
    parameter int BAY_COUNT = BAY_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_req              i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output t_rsp              o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // only the eight mask bits can ever be counted
    localparam int NCOUNT = (BAY_COUNT < MASK_W) ? BAY_COUNT : MASK_W;

    // ---- register bank ----
    logic [CNT_W-1:0]   r_cfg_hold;
    logic [CNT_W-1:0]   r_cfg_blink;
    logic [PULSE_W-1:0] r_cfg_closed;
    logic [PULSE_W-1:0] r_cfg_open;
    logic [CNT_W-1:0]   r_cfg_period;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_hold   <= RST_OPEN_HOLD;
            r_cfg_blink  <= RST_BLINK;
            r_cfg_closed <= RST_CLOSED_PW;
            r_cfg_open   <= RST_OPEN_PW;
            r_cfg_period <= RST_PWM_PERIOD;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_OPEN_HOLD:  r_cfg_hold   <= pwdata[CNT_W-1:0];
                REG_BLINK:      r_cfg_blink  <= pwdata[CNT_W-1:0];
                REG_CLOSED_PW:  r_cfg_closed <= pwdata[PULSE_W-1:0];
                REG_OPEN_PW:    r_cfg_open   <= pwdata[PULSE_W-1:0];
                REG_PWM_PERIOD: r_cfg_period <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_OPEN_HOLD:  prdata = APB_DW'(r_cfg_hold);
            REG_BLINK:      prdata = APB_DW'(r_cfg_blink);
            REG_CLOSED_PW:  prdata = APB_DW'(r_cfg_closed);
            REG_OPEN_PW:    prdata = APB_DW'(r_cfg_open);
            REG_PWM_PERIOD: prdata = APB_DW'(r_cfg_period);
            default:        prdata = '0;
        endcase
    end

    // ---- pipeline control ----
    logic r_in_valid;
    t_req r_in_req;
    logic r_out_valid;
    t_rsp r_out_rsp;
    logic advance;
    logic step;

    assign advance = !r_out_valid || i_ready;
    assign step    = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_req <= i_req;
        end
    end

    // ---- sequencer state ----
    logic               r_seq_active, n_seq_active;
    logic [CNT_W-1:0]   r_blink_cnt,  n_blink_cnt;
    logic [CNT_W-1:0]   r_open_cnt,   n_open_cnt;
    logic               r_yellow,     n_yellow;
    logic [PULSE_W-1:0] r_pulse,      n_pulse;
    logic               r_servo_high, n_servo_high;

    logic [SLOT_W-1:0]  free_slots;
    logic               phase_valid;
    logic [PHASE_W-1:0] phase_us;
    logic [PHASE_W-1:0] low_cur;   // low time with the present pulse width
    logic [PHASE_W-1:0] low_open;  // low time once the open pulse is loaded
    t_rsp               n_out_rsp;

    always_comb begin
        free_slots = '0;
        for (int i = 0; i < NCOUNT; i++) begin
            free_slots = free_slots + SLOT_W'(r_in_req.bay_free_mask[i]);
        end
    end

    // low phase = period - pulse, floored at zero
    assign low_cur  = ({1'b0, r_pulse} >= r_cfg_period) ? '0
                    : r_cfg_period - {1'b0, r_pulse};
    assign low_open = ({1'b0, r_cfg_open} >= r_cfg_period) ? '0
                    : r_cfg_period - {1'b0, r_cfg_open};

    always_comb begin
        n_seq_active = r_seq_active;
        n_blink_cnt  = r_blink_cnt;
        n_open_cnt   = r_open_cnt;
        n_yellow     = r_yellow;
        n_pulse      = r_pulse;
        n_servo_high = r_servo_high;
        phase_valid  = 1'b0;
        phase_us     = '0;
        case (r_in_req.op)
            OP_TICK: begin
                if (r_seq_active) begin
                    n_blink_cnt = (r_blink_cnt != '1) ? r_blink_cnt + 1'b1 : r_blink_cnt;
                    if (n_blink_cnt >= r_cfg_blink) begin
                        n_blink_cnt = '0;
                        n_yellow    = !r_yellow;
                    end
                    n_open_cnt = (r_open_cnt != '1) ? r_open_cnt + 1'b1 : r_open_cnt;
                    // closing wins over any blink toggle
                    if (n_open_cnt >= r_cfg_hold && !r_in_req.vehicle_present) begin
                        n_pulse      = r_cfg_closed;
                        n_yellow     = 1'b0;
                        n_seq_active = 1'b0;
                    end
                end
            end
            OP_ENTRY, OP_EXIT: begin
                if (!r_seq_active && (r_in_req.op == OP_EXIT || free_slots != '0)) begin
                    n_seq_active = 1'b1;
                    n_pulse      = r_cfg_open;
                    n_yellow     = 1'b1;
                    n_open_cnt   = '0;
                    n_blink_cnt  = '0;
                    if (!r_in_req.servo_expiry_pending) begin
                        n_servo_high = 1'b0;
                        phase_valid  = 1'b1;
                        phase_us     = low_open;
                    end
                end
            end
            OP_PHASE: begin
                phase_valid  = 1'b1;
                n_servo_high = !r_servo_high;
                phase_us     = r_servo_high ? low_cur : PHASE_W'(r_pulse);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_rsp.free_slots      = free_slots;
        n_out_rsp.lot_full        = (free_slots == '0);
        n_out_rsp.yellow_on       = n_yellow;
        n_out_rsp.gate_busy       = n_seq_active;
        n_out_rsp.servo_level     = n_servo_high;
        n_out_rsp.phase_valid     = phase_valid;
        n_out_rsp.phase_us        = phase_us;
        n_out_rsp.target_pulse_us = n_pulse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_active <= 1'b0;
            r_blink_cnt  <= '0;
            r_open_cnt   <= '0;
            r_yellow     <= 1'b0;
            r_pulse      <= RST_CLOSED_PW;
            r_servo_high <= 1'b0;
        end else if (step) begin
            r_seq_active <= n_seq_active;
            r_blink_cnt  <= n_blink_cnt;
            r_open_cnt   <= n_open_cnt;
            r_yellow     <= n_yellow;
            r_pulse      <= n_pulse;
            r_servo_high <= n_servo_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_rsp <= n_out_rsp;
        end
    end

endmodule

FILE: src/pgss_chk.sv
// Port-level checker for the parking gate servo sequencer and its bind.
// Depends on pgss_pkg and parking_gate_servo_sequencer_top.
module pgss_chk
    import pgss_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input t_rsp o_rsp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    a_led_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.lot_full == (o_rsp.free_slots == '0))
        else $error("red/green LED disagrees with free count");

    a_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.phase_valid |-> o_rsp.phase_us == '0)
        else $error("phase duration without phase valid");

    a_yellow_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.gate_busy |-> !o_rsp.yellow_on)
        else $error("yellow LED lit with gate idle");

endmodule

bind parking_gate_servo_sequencer_top pgss_chk u_pgss_chk (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for parking_gate_servo_sequencer_top: a gate/servo tracker class
// predicts each status word from the accepted requests. Depends on pgss_pkg and the RTL.
module tb;
    import pgss_pkg::*;

    // Watchdog: cycles with no request and no status accepted before giving up.
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned RANDOM_ITEMS = 860;
    localparam int unsigned PHASES       = 8;

    // Tracks gate state, blink/hold counters and servo level, and holds the status
    // words still owed by the block, oldest first.
    class gate_sequence_tracker;
        logic [15:0] hold_ticks;
        logic [15:0] blink_ticks;
        logic [14:0] closed_us;
        logic [14:0] open_us;
        logic [15:0] period_us;
        bit          gate_open;
        logic [15:0] blink_cnt;
        logic [15:0] hold_cnt;
        bit          yellow;
        logic [15:0] pulse_us;
        bit          pin_high;
        t_rsp        expected_status[$];
        int unsigned mismatches;

        function new();
            hold_ticks  = RST_OPEN_HOLD;
            blink_ticks = RST_BLINK;
            closed_us   = RST_CLOSED_PW;
            open_us     = RST_OPEN_PW;
            period_us   = RST_PWM_PERIOD;
            gate_open   = 1'b0;
            blink_cnt   = '0;
            hold_cnt    = '0;
            yellow      = 1'b0;
            pulse_us    = 16'(RST_CLOSED_PW);
            pin_high    = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_OPEN_HOLD:  hold_ticks  = v[15:0];
                REG_BLINK:      blink_ticks = v[15:0];
                REG_CLOSED_PW:  closed_us   = v[14:0];
                REG_OPEN_PW:    open_us     = v[14:0];
                REG_PWM_PERIOD: period_us   = v[15:0];
                default: ;
            endcase
        endfunction

        // Low part of the servo frame, floored at zero when the pulse overruns the period.
        function logic [15:0] low_span();
            if (pulse_us >= period_us)
                return '0;
            return period_us - pulse_us;
        endfunction

        function int unsigned outstanding();
            return expected_status.size();
        endfunction

        function void note_request(t_req r);
            t_rsp        e;
            int unsigned n;
            n = 0;
            for (int i = 0; i < MASK_W; i++)
                n += r.bay_free_mask[i];
            e = '0;
            case (r.op)
                OP_TICK: begin
                    if (gate_open) begin
                        if (blink_cnt != 16'hFFFF)
                            blink_cnt++;
                        if (blink_cnt >= blink_ticks) begin
                            blink_cnt = '0;
                            yellow    = !yellow;
                        end
                        if (hold_cnt != 16'hFFFF)
                            hold_cnt++;
                        // closing wins over any blink toggle on the same tick
                        if (hold_cnt >= hold_ticks && !r.vehicle_present) begin
                            pulse_us  = 16'(closed_us);
                            yellow    = 1'b0;
                            gate_open = 1'b0;
                        end
                    end
                end
                OP_ENTRY, OP_EXIT: begin
                    if (!gate_open && (r.op == OP_EXIT || n != 0)) begin
                        gate_open = 1'b1;
                        pulse_us  = 16'(open_us);
                        if (!r.servo_expiry_pending) begin
                            pin_high      = 1'b0;
                            e.phase_valid = 1'b1;
                            e.phase_us    = low_span();
                        end
                        yellow    = 1'b1;
                        hold_cnt  = '0;
                        blink_cnt = '0;
                    end
                end
                default: begin
                    e.phase_valid = 1'b1;
                    if (pin_high) begin
                        pin_high   = 1'b0;
                        e.phase_us = low_span();
                    end else begin
                        pin_high   = 1'b1;
                        e.phase_us = pulse_us;
                    end
                end
            endcase
            e.free_slots      = SLOT_W'(n);
            e.lot_full        = (n == 0);
            e.yellow_on       = yellow;
            e.gate_busy       = gate_open;
            e.servo_level     = pin_high;
            e.target_pulse_us = pulse_us[14:0];
            expected_status.push_back(e);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_status(t_rsp a);
            t_rsp e;
            if (expected_status.size() == 0) begin
                mismatches++;
                $display("%0t: status with nothing expected, expected none, actual %h",
                         $time, a);
                return;
            end
            e = expected_status.pop_front();
            compare_field("free_slots",      e.free_slots,      a.free_slots);
            compare_field("lot_full",        e.lot_full,        a.lot_full);
            compare_field("yellow_on",       e.yellow_on,       a.yellow_on);
            compare_field("gate_busy",       e.gate_busy,       a.gate_busy);
            compare_field("servo_level",     e.servo_level,     a.servo_level);
            compare_field("phase_valid",     e.phase_valid,     a.phase_valid);
            compare_field("phase_us",        e.phase_us,        a.phase_us);
            compare_field("target_pulse_us", e.target_pulse_us, a.target_pulse_us);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    t_req              i_req;
    logic              o_valid;
    logic              i_ready;
    t_rsp              o_rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    gate_sequence_tracker tracker;
    int unsigned          sent;
    int unsigned          idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    parking_gate_servo_sequencer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Both handshakes are sampled at the clock edge, ahead of the nonblocking updates, so
    // the tracker sees exactly what the block sees. The watchdog lives here too.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                tracker.note_request(i_req);
            if (o_valid && i_ready)
                tracker.check_status(o_rsp);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one, and no gap at all most of the time.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // Result side back-pressure: ready runs of random length broken by stalls. The odd
    // long run gives stretches with no back-pressure at all.
    initial begin
        int unsigned run;
        int unsigned stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 30);
            i_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = gap_len();
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    function automatic t_req make_req(t_op op, logic [7:0] mask, logic veh, logic pend);
        t_req r;
        r.op                   = op;
        r.bay_free_mask        = mask;
        r.vehicle_present      = veh;
        r.servo_expiry_pending = pend;
        return r;
    endfunction

    // Empty and full lots turn up often; the rest is any mask.
    function automatic logic [7:0] pick_mask();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        if (r < 25)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_req noise_req();
        return make_req(t_op'($urandom_range(0, 3)), pick_mask(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // Valid goes up at an edge and holds, payload steady, until the block takes it.
    // Valid is left high; the caller lowers it through pause() or drain().
    task automatic send(input t_req r);
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic pause(input int unsigned n);
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic issue(input t_req r, input bit gaps);
        send(r);
        if (gaps)
            pause(gap_len());
    endtask

    // Hold the request side off until every status word is in, plus a short margin.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup cycle, access cycle; the register takes the value at the access edge.
    // An extra edge at the end keeps back-to-back writes from touching psel twice in a step.
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tracker.write_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_gate(input logic [15:0] hold, input logic [15:0] blink,
                                input logic [14:0] cpw, input logic [14:0] opw,
                                input logic [15:0] period);
        drain();
        apb_write(REG_OPEN_HOLD, 32'(hold));
        apb_write(REG_BLINK, 32'(blink));
        apb_write(REG_CLOSED_PW, 32'(cpw));
        apb_write(REG_OPEN_PW, 32'(opw));
        apb_write(REG_PWM_PERIOD, 32'(period));
    endtask

    // Phase 0 keeps the reset settings; 1 and 2 are the extremes; the rest are random
    // with short hold times so that the gate really cycles.
    task automatic configure(input int p);
        logic [15:0] period;
        period = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(15000, 25000));
        case (p)
            0: ;
            1: program_gate(16'd1, 16'd1, 15'd0, 15'd20000, 16'd1);
            2: program_gate(16'd5, 16'd65535, 15'd20000, 15'd0, 16'd65535);
            default: program_gate(16'($urandom_range(1, 40)), 16'($urandom_range(1, 12)),
                                  15'($urandom_range(0, 20000)),
                                  15'($urandom_range(0, 20000)), period);
        endcase
    endtask

    // One open/close round: an entry or exit request, then a run of mostly ticks, about as
    // long as the hold time but at most 60, with servo phase ends and stray requests mixed in.
    task automatic gate_cycle(input bit gaps);
        t_req        r;
        int unsigned n;
        int unsigned pick;
        r    = noise_req();
        r.op = ($urandom_range(0, 2) == 0) ? OP_EXIT : OP_ENTRY;
        issue(r, gaps);
        n = tracker.hold_ticks + $urandom_range(0, 4);
        if (n > 60)
            n = $urandom_range(1, 60);
        repeat (n) begin
            r    = noise_req();
            pick = $urandom_range(0, 99);
            if (pick < 75)
                r.op = OP_TICK;
            else if (pick < 90)
                r.op = OP_PHASE;
            else
                r.op = ($urandom_range(0, 1) != 0) ? OP_ENTRY : OP_EXIT;
            r.vehicle_present = ($urandom_range(0, 99) < 15);
            issue(r, gaps);
        end
    endtask

    initial begin
        bit          quiet;
        int unsigned target;
        tracker = new();
        sent    = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset settings first: idle tick, servo alternation, entry into
        // a full lot, opening with re-arm, requests while busy.
        issue(make_req(OP_TICK, 8'hFF, 1'b1, 1'b1), 1'b1);
        issue(make_req(OP_PHASE, 8'h00, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_PHASE, 8'h01, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_ENTRY, 8'h00, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_ENTRY, 8'h80, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_ENTRY, 8'hFF, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_EXIT, 8'h55, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_TICK, 8'hAA, 1'b1, 1'b0), 1'b1);
        // Short hold: a vehicle keeps the gate open, then it closes; then an exit
        // with a servo expiry pending leaves the raised pin alone.
        program_gate(16'd2, 16'd1, RST_CLOSED_PW, RST_OPEN_PW, RST_PWM_PERIOD);
        issue(make_req(OP_TICK, 8'h0F, 1'b1, 1'b0), 1'b1);
        issue(make_req(OP_TICK, 8'hF0, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_PHASE, 8'h3C, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_EXIT, 8'h00, 1'b0, 1'b1), 1'b1);
        issue(make_req(OP_PHASE, 8'hC3, 1'b1, 1'b1), 1'b1);
        // Pulse wider than the frame: the low part floors at zero.
        program_gate(16'd2, 16'd1, 15'd0, 15'd20000, 16'd1);
        issue(make_req(OP_TICK, 8'h01, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_TICK, 8'h02, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_PHASE, 8'h04, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_PHASE, 8'h08, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_EXIT, 8'h10, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_PHASE, 8'h20, 1'b0, 1'b0), 1'b1);
        issue(make_req(OP_PHASE, 8'h40, 1'b0, 1'b0), 1'b1);

        // Random part: mostly whole gate rounds with random fields, some loose noise.
        // Every third phase runs without sender gaps; now and then the sender waits
        // for the block to empty completely.
        for (int p = 0; p < PHASES; p++) begin
            configure(p);
            quiet  = (p % 3 == 2);
            target = sent + RANDOM_ITEMS / PHASES;
            while (sent < target) begin
                if ($urandom_range(0, 99) < 70)
                    gate_cycle(!quiet);
                else
                    issue(noise_req(), !quiet);
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
        end

        // Longest hold and blink: a run of ticks, some with a vehicle, leaves the gate
        // open and the yellow LED steady; a phase end follows.
        program_gate(16'd65535, 16'd65535, 15'($urandom_range(0, 20000)),
                     15'($urandom_range(0, 20000)), 16'($urandom_range(1, 65535)));
        issue(make_req(OP_EXIT, pick_mask(), 1'b0, 1'b0), 1'b0);
        repeat (20)
            issue(make_req(OP_TICK, pick_mask(), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1))), 1'b0);
        issue(make_req(OP_TICK, pick_mask(), 1'b0, 1'b0), 1'b0);
        issue(make_req(OP_PHASE, pick_mask(), 1'b0, 1'b0), 1'b0);

        // Let the last status words in, then a few more edges to catch strays.
        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
